### rtl/dps_pkg.sv
// Shared types, field widths and codes of the dynamic priority scheduler.
package dps_pkg;

   // Field widths of one task and of the stream transactions.
   localparam int ID_WIDTH      = 8;
   localparam int LIFE_WIDTH    = 4;
   localparam int PRIO_WIDTH    = 6;
   localparam int RUNTIME_WIDTH = 4;
   localparam int COUNT_WIDTH   = 5;
   localparam int REQ_WIDTH     = 24;
   localparam int RSP_WIDTH     = 40;

   localparam int READY_DEPTH_DEFAULT = 16;

   // Priority decays by this divisor on every tick that the task runs.
   localparam int DECAY_DIVISOR = 2;
   localparam int DECAY_SHIFT   = $clog2(DECAY_DIVISOR);

   // Start phase: the head is dispatched when the phase reaches one.
   localparam logic [1:0] PHASE_IDLE     = 2'd0;
   localparam logic [1:0] PHASE_DISPATCH = 2'd1;
   localparam logic [1:0] PHASE_MAX      = 2'd2;

   localparam logic OP_CREATE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      OUTCOME_OK,
      OUTCOME_FULL,
      OUTCOME_ZERO_LIFE
   } outcome_type;

   typedef struct packed {
      logic [ID_WIDTH-1:0]      id;
      logic [LIFE_WIDTH-1:0]    life;
      logic [PRIO_WIDTH-1:0]    prio;
      logic [RUNTIME_WIDTH-1:0] runtime;
   } task_type;

   // Operation broadcast to every cell of the ready table.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_POP,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      task_type    item;
   } chain_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CREATE,
      ST_DISPATCH,
      ST_RUN,
      ST_REINSERT,
      ST_REPORT
   } state_type;

endpackage

### rtl/dps_cell.sv
// One slot of the sorted ready table, linked to its two neighbors.
module dps_cell #(
   parameter int INDEX      = 0,
   parameter int SIZE_WIDTH = 5
) (
   input  logic                      clock,
   input  dps_pkg::chain_ctrl_type   ctrl,
   input  logic [SIZE_WIDTH-1:0]     size,
   input  dps_pkg::task_type         left_entry,
   input  logic                      left_open,
   input  dps_pkg::task_type         right_entry,
   output dps_pkg::task_type         entry,
   output logic                      open
);
   import dps_pkg::*;

   task_type entry_ff;
   task_type entry_in;
   logic     occupied;

   // A slot is open to the new item when it is empty or holds a lower
   // priority; this is monotonic along the row, so the first open slot
   // is where the item lands, behind all equal priorities.
   assign occupied = SIZE_WIDTH'(INDEX) < size;
   assign open     = !occupied || (entry_ff.prio < ctrl.item.prio);
   assign entry    = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         CELL_HOLD: entry_in = entry_ff;
         CELL_POP:  entry_in = right_entry;
         CELL_INSERT: begin
            if (open && !left_open) begin
               entry_in = ctrl.item;
            end else if (open) begin
               entry_in = left_entry;
            end
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### rtl/dynamic_priority_scheduler.sv
// Top level of the dynamic priority scheduler: sequencer, run slot and ready table.
//
// This block schedules tasks preemptively by priority. A create transaction
// (req_tuser low) inserts a task into a ready table that a row of cells keeps
// sorted by priority, highest first, with equal priorities in arrival order;
// it is refused with outcome 2 when its life is zero and with outcome 1 when
// the table is full. A tick transaction (req_tuser high) first dispatches the
// table head on the first tick after the scheduler went idle, then runs the
// task in the run slot for one tick (runtime up by one, life down by one,
// priority halved), and finally either finishes it, reporting its id and
// runtime and dispatching the head, lets a strictly higher-priority head
// preempt it, in which case the preempted task goes back behind the tasks
// of equal priority, or keeps it in the run slot. Every request transaction
// gives exactly one response transaction, carrying the outcome, the run slot
// after the item, any finished task and the number of waiting tasks. Items
// are handled one at a time by a sequencer that performs at most one table
// operation (a pop or a sorted insert, each done by all cells at once) per
// clock cycle. A create passes through the accepting cycle, the insert step
// and the report step, and its response register is loaded in the report
// step. A tick passes through the accepting cycle and the dispatch step,
// which is always taken; a task in the run slot adds the run step, a
// preemption adds the reinsert step, and the report step ends it. The
// response register separates the two sides, so a new request is accepted
// while the previous response still waits, and a stalled response adds
// cycles only once the next item is ready to report. The reset is
// synchronous and active high; no clearing pass is needed.
module dynamic_priority_scheduler #(
   parameter int READY_DEPTH = dps_pkg::READY_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0 up: task_id[7:0], task_life[11:8],
   // task_priority[17:12], zero fill [23:18].
   input  logic [dps_pkg::REQ_WIDTH-1:0]  req_tdata,
   // Field: operation (0 create, 1 tick).
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0 up: outcome[1:0], running_valid[2], running_id[10:3],
   // running_priority[16:11], running_life[20:17], finished_valid[21],
   // finished_id[29:22], finished_runtime[33:30], ready_count[38:34],
   // zero fill [39].
   output logic [dps_pkg::RSP_WIDTH-1:0]  rsp_tdata
);
   import dps_pkg::*;

   localparam int SIZE_WIDTH = $clog2(READY_DEPTH + 1);

   // Sequencer state and the accepted request.
   state_type                 state_ff, state_in;
   logic [ID_WIDTH-1:0]       item_id_ff, item_id_in;
   logic [LIFE_WIDTH-1:0]     item_life_ff, item_life_in;
   logic [PRIO_WIDTH-1:0]     item_prio_ff, item_prio_in;

   // Scheduler state.
   logic [SIZE_WIDTH-1:0]     size_ff, size_in;
   task_type                  run_ff, run_in;
   logic                      run_present_ff, run_present_in;
   logic [1:0]                phase_ff, phase_in;
   task_type                  spare_ff, spare_in;

   // Result of the item under way.
   outcome_type               outcome_ff, outcome_in;
   logic                      fin_valid_ff, fin_valid_in;
   logic [ID_WIDTH-1:0]       fin_id_ff, fin_id_in;
   logic [RUNTIME_WIDTH-1:0]  fin_runtime_ff, fin_runtime_in;

   // Response register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]      rsp_data_ff, rsp_data_in;

   logic                      req_accept;
   logic                      rsp_free;
   logic [1:0]                phase_step;
   task_type                  decayed;
   task_type                  head;
   chain_ctrl_type            chain_ctrl;
   logic                      table_empty;
   logic                      table_full;

   task_type                  cell_entry [READY_DEPTH];
   logic                      cell_open  [READY_DEPTH];

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;
   assign head        = cell_entry[0];
   assign table_empty = (size_ff == '0);
   assign table_full  = (size_ff >= SIZE_WIDTH'(READY_DEPTH));

   // The start phase counts ticks and saturates.
   assign phase_step = (phase_ff == PHASE_MAX) ? phase_ff : phase_ff + 2'd1;

   // The running task after one tick of work.
   always_comb begin
      decayed         = run_ff;
      decayed.runtime = run_ff.runtime + 1'b1;
      decayed.life    = run_ff.life - 1'b1;
      decayed.prio    = run_ff.prio >> DECAY_SHIFT;
   end

   // Ready table: a row of cells, each taking its right neighbor on a pop
   // and its left neighbor or the new item on an insert.
   for (genvar i = 0; i < READY_DEPTH; i++) begin : g_cell
      task_type left_entry;
      logic     left_open;
      task_type right_entry;

      if (i == 0) begin : g_first
         assign left_entry = chain_ctrl.item;
         assign left_open  = 1'b0;
      end else begin : g_inner
         assign left_entry = cell_entry[i-1];
         assign left_open  = cell_open[i-1];
      end

      if (i == READY_DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      dps_cell #(
         .INDEX      (i),
         .SIZE_WIDTH (SIZE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctrl        (chain_ctrl),
         .size        (size_ff),
         .left_entry  (left_entry),
         .left_open   (left_open),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .open        (cell_open[i])
      );
   end

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == OP_CREATE) ? ST_CREATE : ST_DISPATCH;
            end
         end
         ST_CREATE: state_in = ST_REPORT;
         ST_DISPATCH: begin
            if (phase_step == PHASE_DISPATCH) begin
               state_in = table_empty ? ST_REPORT : ST_RUN;
            end else begin
               state_in = run_present_ff ? ST_RUN : ST_REPORT;
            end
         end
         ST_RUN: begin
            if (decayed.life != '0 && !table_empty && decayed.prio < head.prio) begin
               state_in = ST_REINSERT;
            end else begin
               state_in = ST_REPORT;
            end
         end
         ST_REINSERT: state_in = ST_REPORT;
         ST_REPORT: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and table operations of each sequencer state.
   always_comb begin
      item_id_in      = item_id_ff;
      item_life_in    = item_life_ff;
      item_prio_in    = item_prio_ff;
      size_in         = size_ff;
      run_in          = run_ff;
      run_present_in  = run_present_ff;
      phase_in        = phase_ff;
      spare_in        = spare_ff;
      outcome_in      = outcome_ff;
      fin_valid_in    = fin_valid_ff;
      fin_id_in       = fin_id_ff;
      fin_runtime_in  = fin_runtime_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      chain_ctrl.op   = CELL_HOLD;
      chain_ctrl.item = spare_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_id_in     = req_tdata[7:0];
               item_life_in   = req_tdata[11:8];
               item_prio_in   = req_tdata[17:12];
               outcome_in     = OUTCOME_OK;
               fin_valid_in   = 1'b0;
               fin_id_in      = '0;
               fin_runtime_in = '0;
            end
         end
         ST_CREATE: begin
            // Zero life is refused before a full table is.
            if (item_life_ff == '0) begin
               outcome_in = OUTCOME_ZERO_LIFE;
            end else if (table_full) begin
               outcome_in = OUTCOME_FULL;
            end else begin
               chain_ctrl.op           = CELL_INSERT;
               chain_ctrl.item.id      = item_id_ff;
               chain_ctrl.item.life    = item_life_ff;
               chain_ctrl.item.prio    = item_prio_ff;
               chain_ctrl.item.runtime = '0;
               size_in                 = size_ff + 1'b1;
            end
         end
         ST_DISPATCH: begin
            phase_in = phase_step;
            if (phase_step == PHASE_DISPATCH) begin
               if (table_empty) begin
                  run_present_in = 1'b0;
               end else begin
                  run_in         = head;
                  run_present_in = 1'b1;
                  chain_ctrl.op  = CELL_POP;
                  size_in        = size_ff - 1'b1;
               end
            end else if (!run_present_ff) begin
               // Idle tick: dispatch waits for the following tick.
               phase_in = PHASE_IDLE;
            end
         end
         ST_RUN: begin
            if (decayed.life == '0) begin
               fin_valid_in   = 1'b1;
               fin_id_in      = decayed.id;
               fin_runtime_in = decayed.runtime;
               if (table_empty) begin
                  run_present_in = 1'b0;
               end else begin
                  run_in        = head;
                  chain_ctrl.op = CELL_POP;
                  size_in       = size_ff - 1'b1;
               end
            end else if (!table_empty && decayed.prio < head.prio) begin
               // Preemption: pop now, reinsert the old task next cycle, so
               // the table never overflows.
               run_in        = head;
               spare_in      = decayed;
               chain_ctrl.op = CELL_POP;
               size_in       = size_ff - 1'b1;
            end else begin
               run_in = decayed;
            end
         end
         ST_REINSERT: begin
            chain_ctrl.op   = CELL_INSERT;
            chain_ctrl.item = spare_ff;
            size_in         = size_ff + 1'b1;
         end
         ST_REPORT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               COUNT_WIDTH'(size_ff),
                               fin_runtime_ff,
                               fin_id_ff,
                               fin_valid_ff,
                               run_present_ff ? run_ff.life : {LIFE_WIDTH{1'b0}},
                               run_present_ff ? run_ff.prio : {PRIO_WIDTH{1'b0}},
                               run_present_ff ? run_ff.id : {ID_WIDTH{1'b0}},
                               run_present_ff,
                               outcome_ff};
            end
         end
         default: begin
            chain_ctrl.op = CELL_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         size_ff        <= '0;
         run_present_ff <= 1'b0;
         phase_ff       <= PHASE_IDLE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         size_ff        <= size_in;
         run_present_ff <= run_present_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_id_ff     <= item_id_in;
      item_life_ff   <= item_life_in;
      item_prio_ff   <= item_prio_in;
      run_ff         <= run_in;
      spare_ff       <= spare_in;
      outcome_ff     <= outcome_in;
      fin_valid_ff   <= fin_valid_in;
      fin_id_ff      <= fin_id_in;
      fin_runtime_ff <= fin_runtime_in;
      rsp_data_ff    <= rsp_data_in;
   end

`ifndef SYNTH
   // An insert never reaches a full table, whether from a create or a reinsert.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      chain_ctrl.op == CELL_INSERT |-> !table_full)
      else $error("insert issued to a full ready table");

   // A pop only takes an existing head.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      chain_ctrl.op == CELL_POP |-> !table_empty)
      else $error("pop issued to an empty ready table");

   // A new response appears only after the report step of an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(state_ff == ST_REPORT))
      else $error("response loaded outside the report step");

   // A create item leaves the run slot and start phase alone.
   a_create_keeps_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CREATE |=> $stable(run_present_ff) && $stable(phase_ff))
      else $error("create changed the run slot or start phase");
`endif

endmodule

### sim/dynamic_priority_scheduler_tb.sv
// Self-checking testbench of the dynamic priority scheduler, with a scheduling predictor.
`timescale 1ns / 100ps

module dynamic_priority_scheduler_tb;
   import dps_pkg::*;

   // The block is built with its default table depth.
   localparam int TABLE_DEPTH = READY_DEPTH_DEFAULT;

   // A run ends when this many cycles pass without any transaction.
   localparam int WATCHDOG_LIMIT = 3000;
   // The receiver's long hold-off, which fills the block and stalls its input.
   localparam int HOLD_CYCLES = 400;
   // Cycles allowed for any late response after the last expected one.
   localparam int DRAIN_CYCLES = 20;
   localparam int PHASE_COUNT = 37;
   localparam int PHASE_ITEMS = 50;

   // Response fields in the layout of rsp_tdata; the first member is the top bit.
   typedef struct packed {
      logic                     fill;
      logic [COUNT_WIDTH-1:0]   ready_count;
      logic [RUNTIME_WIDTH-1:0] finished_runtime;
      logic [ID_WIDTH-1:0]      finished_id;
      logic                     finished_valid;
      logic [LIFE_WIDTH-1:0]    running_life;
      logic [PRIO_WIDTH-1:0]    running_priority;
      logic [ID_WIDTH-1:0]      running_id;
      logic                     running_valid;
      logic [1:0]               outcome;
   } report_fields_type;

   // Tracks the scheduler state on its own and keeps the reports that the block
   // still owes, oldest first.
   class schedule_tracker;
      task_type          ready_table [TABLE_DEPTH];
      int                ready_size;
      task_type          run_task;
      bit                run_busy;
      logic [1:0]        phase;
      report_fields_type pending_reports [$];
      int                mismatches;

      function new();
         ready_size = 0;
         run_task   = '0;
         run_busy   = 1'b0;
         phase      = PHASE_IDLE;
         mismatches = 0;
      endfunction

      function task_type take_head();
         task_type head;
         head = ready_table[0];
         for (int i = 1; i < ready_size; i++) begin
            ready_table[i-1] = ready_table[i];
         end
         ready_size--;
         return head;
      endfunction

      // Equal priorities stay in arrival order: a new task goes behind them.
      function void insert_by_priority(task_type entry);
         int pos;
         pos = 0;
         if (ready_size >= TABLE_DEPTH) begin
            return;
         end
         while (pos < ready_size && ready_table[pos].prio >= entry.prio) begin
            pos++;
         end
         for (int i = ready_size; i > pos; i--) begin
            ready_table[i] = ready_table[i-1];
         end
         ready_table[pos] = entry;
         ready_size++;
      endfunction

      // Advances the predicted state by one accepted request and queues the report.
      function void admit_item(logic op, logic [ID_WIDTH-1:0] id,
                               logic [LIFE_WIDTH-1:0] life, logic [PRIO_WIDTH-1:0] prio);
         report_fields_type want;
         task_type          fresh;
         task_type          done;
         task_type          head;
         bit                finished;
         bit                proceed;
         want     = '0;
         done     = '0;
         finished = 1'b0;
         if (op == OP_CREATE) begin
            // Zero life is refused even when the table is also full.
            if (life == '0) begin
               want.outcome = OUTCOME_ZERO_LIFE;
            end else if (ready_size >= TABLE_DEPTH) begin
               want.outcome = OUTCOME_FULL;
            end else begin
               fresh.id      = id;
               fresh.life    = life;
               fresh.prio    = prio;
               fresh.runtime = '0;
               insert_by_priority(fresh);
               want.outcome = OUTCOME_OK;
            end
         end else begin
            proceed = 1'b1;
            if (phase < PHASE_MAX) begin
               phase = phase + 2'd1;
            end
            if (phase == PHASE_DISPATCH) begin
               if (ready_size == 0) begin
                  run_busy = 1'b0;
                  proceed  = 1'b0;
               end else begin
                  run_task = take_head();
                  run_busy = 1'b1;
               end
            end
            // An idle scheduler drops back so that the next tick dispatches.
            if (proceed && !run_busy) begin
               phase   = PHASE_IDLE;
               proceed = 1'b0;
            end
            if (proceed) begin
               run_task.runtime = run_task.runtime + 1'b1;
               run_task.life    = run_task.life - 1'b1;
               run_task.prio    = PRIO_WIDTH'(run_task.prio / DECAY_DIVISOR);
               if (run_task.life == '0) begin
                  finished = 1'b1;
                  done     = run_task;
                  run_busy = 1'b0;
                  if (ready_size > 0) begin
                     run_task = take_head();
                     run_busy = 1'b1;
                  end
               end else if (ready_size > 0 && run_task.prio < ready_table[0].prio) begin
                  // The head leaves before the preempted task goes back, so a
                  // full table never overflows.
                  head = take_head();
                  insert_by_priority(run_task);
                  run_task = head;
               end
            end
         end
         want.running_valid = run_busy;
         if (run_busy) begin
            want.running_id       = run_task.id;
            want.running_priority = run_task.prio;
            want.running_life     = run_task.life;
         end
         want.finished_valid = finished;
         if (finished) begin
            want.finished_id      = done.id;
            want.finished_runtime = done.runtime;
         end
         want.ready_count = COUNT_WIDTH'(ready_size);
         pending_reports.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_report(logic [RSP_WIDTH-1:0] data);
         report_fields_type want;
         report_fields_type got;
         got = data;
         if (pending_reports.size() == 0) begin
            $display("%0t: response with none pending, expected nothing, actual %h",
                     $time, data);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         compare_field("outcome", want.outcome, got.outcome);
         compare_field("running_valid", want.running_valid, got.running_valid);
         compare_field("running_id", want.running_id, got.running_id);
         compare_field("running_priority", want.running_priority, got.running_priority);
         compare_field("running_life", want.running_life, got.running_life);
         compare_field("finished_valid", want.finished_valid, got.finished_valid);
         compare_field("finished_id", want.finished_id, got.finished_id);
         compare_field("finished_runtime", want.finished_runtime, got.finished_runtime);
         compare_field("ready_count", want.ready_count, got.ready_count);
         compare_field("zero fill", want.fill, got.fill);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata;
   logic                 req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;

   schedule_tracker tracker = new();

   // When set, neither side inserts gaps.
   bit steady;
   // Raised by the stimulus to ask the receiver for one long hold-off.
   bit hold_request;
   int quiet_cycles;

   // Directed table fill: the ids run from 0 to 255 in steps of 17; the
   // priorities hold both extremes and several ties.
   int fill_prio [16] = '{63, 0, 5, 5, 5, 63, 32, 1, 17, 5, 0, 62, 31, 8, 63, 16};
   int fill_life [16] = '{1, 15, 2, 3, 1, 4, 7, 15, 2, 9, 1, 3, 5, 6, 2, 8};

   dynamic_priority_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (steady) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end
      if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      if (roll < 98) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   // Offers one request transaction after an optional gap and returns at the
   // clock edge that accepts it. The valid stays high for a following item
   // unless that item starts with a gap.
   task automatic send_item(logic op, logic [ID_WIDTH-1:0] id,
                            logic [LIFE_WIDTH-1:0] life, logic [PRIO_WIDTH-1:0] prio);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_WIDTH - ID_WIDTH - LIFE_WIDTH - PRIO_WIDTH){1'b0}}, prio, life, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Monitor: both channels are sampled at the rising edge, before any
   // nonblocking update of that edge lands. A request is noted before a
   // response of the same edge is checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.admit_item(req_tuser, req_tdata[7:0], req_tdata[11:8], req_tdata[17:12]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_report(rsp_tdata);
         end
      end
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("dynamic_priority_scheduler_tb: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin : response_sink
      int stall;
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      int create_pct;
      int zero_pct;
      int life_top;
      bit narrow;
      logic op;
      logic [LIFE_WIDTH-1:0] life;
      logic [PRIO_WIDTH-1:0] prio;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tuser    = OP_CREATE;
      req_tdata    = '0;
      steady       = 1'b0;
      hold_request = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Two ticks on an empty scheduler: the first finds nothing to dispatch,
      // the second sends the start phase back to idle.
      send_item(OP_TICK, ID_WIDTH'($urandom), LIFE_WIDTH'($urandom), PRIO_WIDTH'($urandom));
      send_item(OP_TICK, ID_WIDTH'($urandom), LIFE_WIDTH'($urandom), PRIO_WIDTH'($urandom));
      send_item(OP_CREATE, 8'hFF, 4'd0, 6'd63);
      for (int i = 0; i < 16; i++) begin
         send_item(OP_CREATE, 8'(i * 17), 4'(fill_life[i]), 6'(fill_prio[i]));
      end
      // With the table full, zero life must still win over the full code.
      send_item(OP_CREATE, 8'h3C, 4'd0, 6'd40);
      send_item(OP_CREATE, 8'hC3, 4'd15, 6'd63);
      // Dispatch, an immediate finish, then decay and preemption.
      repeat (4) begin
         send_item(OP_TICK, ID_WIDTH'($urandom), LIFE_WIDTH'($urandom),
                   PRIO_WIDTH'($urandom));
      end

      // Random phases, each with its own mix: filling bursts, draining runs
      // that take the scheduler back to idle, balanced traffic, and noise
      // with many refused creates.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         steady = ($urandom_range(0, 4) == 0);
         narrow = ($urandom_range(0, 2) == 0);
         life_top = ($urandom_range(0, 1) == 0) ? 3 : 15;
         zero_pct = 5;
         case ($urandom_range(0, 3))
            0: create_pct = 80;
            1: create_pct = 15;
            2: create_pct = 50;
            default: begin
               create_pct = 60;
               zero_pct   = 30;
            end
         endcase
         if (p == 3) begin
            hold_request = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            op = ($urandom_range(0, 99) < create_pct) ? OP_CREATE : OP_TICK;
            if ($urandom_range(0, 99) < zero_pct) begin
               life = '0;
            end else begin
               life = LIFE_WIDTH'($urandom_range(1, life_top));
            end
            if (narrow) begin
               case ($urandom_range(0, 3))
                  0: prio = 6'd0;
                  1: prio = 6'd1;
                  2: prio = 6'd32;
                  default: prio = 6'd63;
               endcase
            end else begin
               prio = PRIO_WIDTH'($urandom_range(0, 63));
            end
            send_item(op, ID_WIDTH'($urandom), life, prio);
         end
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      // The monitor notes the last request at the edge just passed, so the
      // wait checks the pending reports only from the next edge on. The watchdog
      // bounds it if a response never comes.
      do begin
         @(posedge clock);
      end while (tracker.pending_reports.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("dynamic_priority_scheduler_tb: PASS");
      end else begin
         $display("dynamic_priority_scheduler_tb: FAIL");
      end
      $finish;
   end

endmodule
